>>> src/bbf_pkg.sv
// ---------------------------------------------------------------------------
// bbf_pkg
// Shared types and constants of the blocked Bloom filter unit.
// ---------------------------------------------------------------------------
`default_nettype none

package bbf_pkg;

	localparam int MAX_BLOCKS = 1024;
	localparam int BLOCK_BITS = 512;
	localparam int MAX_HASHES = 16;
	localparam int HASH_W     = 64;
	localparam int ROW_AW     = $clog2(MAX_BLOCKS);
	localparam int POS_W      = $clog2(BLOCK_BITS);
	localparam int NB_W       = 11;
	localparam int NH_W       = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;
	localparam int DIV_CNT_W  = $clog2(HASH_W);

	localparam logic [CFG_IDX_W-1:0] REG_NUM_BLOCKS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_HASHES = 2'd1;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_READ,
		ST_MOD
	} bbf_state_t;

	typedef struct packed {
		logic              done;
		logic [ROW_AW-1:0] rem;
	} bbf_div_stat_t;

endpackage

`default_nettype wire

>>> src/bbf_divider.sv
// ---------------------------------------------------------------------------
// bbf_divider
// Radix-2 restoring remainder unit: 64-bit dividend modulo block count,
// one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module bbf_divider (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [bbf_pkg::HASH_W-1:0] dividend,
	input  wire logic [bbf_pkg::NB_W-1:0]   divisor,
	output bbf_pkg::bbf_div_stat_t          stat
);

	logic [bbf_pkg::HASH_W-1:0]    dvd_q;
	logic [bbf_pkg::NB_W-1:0]      dvs_q;
	logic [bbf_pkg::ROW_AW-1:0]    rem_q;
	logic [bbf_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [bbf_pkg::NB_W-1:0]      shifted;
	logic [bbf_pkg::NB_W-1:0]      diff;
	logic                          fits;

	assign shifted = {rem_q, dvd_q[bbf_pkg::HASH_W-1]};
	assign fits    = (shifted >= dvs_q);
	assign diff    = shifted - dvs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '1;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[bbf_pkg::HASH_W-2:0], 1'b0};
			rem_q <= fits ? diff[bbf_pkg::ROW_AW-1:0] : shifted[bbf_pkg::ROW_AW-1:0];
		end
	end

	assign stat.done = done_q;
	assign stat.rem  = rem_q;

endmodule

`default_nettype wire

>>> src/blocked_bloom_filter_unit.sv
// ---------------------------------------------------------------------------
// blocked_bloom_filter_unit
// Blocked Bloom filter over 1024 rows of 512 bits: insert sets and query
// tests up to 16 bit positions inside the row hash_first mod num_blocks.
// ---------------------------------------------------------------------------
//  channel | signals                                  | transaction when
//  in      | in_valid in_ready opcode hash_first/second | in_valid & in_ready
//  out     | out_valid out_ready present              | out_valid & out_ready
//  cfg     | cfg_we cfg_index cfg_data                | cfg_we
//
//  An item occupies the unit from accept to next accept: the bit-serial
//  block-select remainder (64 steps, then the done flag), one row read, one
//  row write or result load, and the idle cycle that takes the next
//  transaction. A result load waits while the output register holds an untaken result.
//  The bit mask is built during the remainder, one position per cycle.
//  After reset a clearing pass zeroes the RAM, one row a cycle; in_ready
//  stays low meanwhile. A query result waits in the output register; the
//  next item is taken while it waits.
// ---------------------------------------------------------------------------
`default_nettype none

module blocked_bloom_filter_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [bbf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bbf_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic                           opcode,
	input  wire logic [bbf_pkg::HASH_W-1:0]     hash_first,
	input  wire logic [bbf_pkg::HASH_W-1:0]     hash_second,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic                                present
);

	bbf_pkg::bbf_state_t state_q, state_d;

	logic [bbf_pkg::NB_W-1:0]       num_blocks_q;
	logic [bbf_pkg::NH_W-1:0]       num_hashes_q;
	logic [bbf_pkg::NB_W-1:0]       eff_blocks;
	logic [bbf_pkg::NH_W-1:0]       eff_hashes;

	logic [bbf_pkg::ROW_AW-1:0]     clr_q;
	logic                           op_q;
	logic [bbf_pkg::POS_W-1:0]      stride_q;
	logic [bbf_pkg::POS_W-1:0]      pos_q;
	logic [bbf_pkg::NH_W-1:0]       hleft_q;
	logic [bbf_pkg::BLOCK_BITS-1:0] mask_q;
	logic                           out_valid_q;
	logic                           present_q;

	logic [bbf_pkg::BLOCK_BITS-1:0] mem [bbf_pkg::MAX_BLOCKS];
	logic [bbf_pkg::BLOCK_BITS-1:0] rdata_q;
	logic                           mem_re;
	logic                           mem_we;
	logic [bbf_pkg::ROW_AW-1:0]     mem_waddr;
	logic [bbf_pkg::BLOCK_BITS-1:0] mem_wdata;

	logic                           accept;
	logic                           load_out;
	logic                           clr_active;
	bbf_pkg::bbf_div_stat_t         div_stat;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_blocks_q <= bbf_pkg::NB_W'(1);
			num_hashes_q <= bbf_pkg::NH_W'(7);
		end else if (cfg_we) begin
			case (cfg_index)
				bbf_pkg::REG_NUM_BLOCKS: num_blocks_q <= cfg_data[bbf_pkg::NB_W-1:0];
				bbf_pkg::REG_NUM_HASHES: num_hashes_q <= cfg_data[bbf_pkg::NH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (num_blocks_q == '0)
			eff_blocks = bbf_pkg::NB_W'(1);
		else if (num_blocks_q > bbf_pkg::NB_W'(bbf_pkg::MAX_BLOCKS))
			eff_blocks = bbf_pkg::NB_W'(bbf_pkg::MAX_BLOCKS);
		else
			eff_blocks = num_blocks_q;
	end

	assign eff_hashes = (num_hashes_q > bbf_pkg::NH_W'(bbf_pkg::MAX_HASHES)) ?
		bbf_pkg::NH_W'(bbf_pkg::MAX_HASHES) : num_hashes_q;

	// block select remainder
	bbf_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.dividend (hash_first),
		.divisor  (eff_blocks),
		.stat     (div_stat)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bbf_pkg::ST_CLEAR: begin
				if (clr_q == '1) state_d = bbf_pkg::ST_IDLE;
			end
			bbf_pkg::ST_IDLE: begin
				if (in_valid) state_d = bbf_pkg::ST_DIV;
			end
			bbf_pkg::ST_DIV: begin
				if (div_stat.done) state_d = bbf_pkg::ST_READ;
			end
			bbf_pkg::ST_READ: begin
				state_d = bbf_pkg::ST_MOD;
			end
			bbf_pkg::ST_MOD: begin
				if (op_q == bbf_pkg::OP_INSERT || !out_valid_q || out_ready)
					state_d = bbf_pkg::ST_IDLE;
			end
			default: state_d = bbf_pkg::ST_CLEAR;
		endcase
	end

	// state outputs
	always_comb begin
		in_ready   = 1'b0;
		clr_active = 1'b0;
		mem_re     = 1'b0;
		mem_we     = 1'b0;
		mem_waddr  = div_stat.rem;
		mem_wdata  = rdata_q | mask_q;
		load_out   = 1'b0;
		case (state_q)
			bbf_pkg::ST_CLEAR: begin
				clr_active = 1'b1;
				mem_we     = 1'b1;
				mem_waddr  = clr_q;
				mem_wdata  = '0;
			end
			bbf_pkg::ST_IDLE: begin
				in_ready = 1'b1;
			end
			bbf_pkg::ST_READ: begin
				mem_re = 1'b1;
			end
			bbf_pkg::ST_MOD: begin
				if (op_q == bbf_pkg::OP_INSERT)
					mem_we = 1'b1;
				else
					load_out = !out_valid_q || out_ready;
			end
			default: ;
		endcase
	end

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bbf_pkg::ST_CLEAR;
			clr_q       <= '0;
			hleft_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clr_active) clr_q <= clr_q + 1'b1;
			if (accept)
				hleft_q <= eff_hashes;
			else if (hleft_q != '0)
				hleft_q <= hleft_q - 1'b1;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// item registers and mask build, one position per cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= opcode;
			stride_q <= hash_second[bbf_pkg::POS_W-1:0];
			pos_q    <= hash_first[bbf_pkg::POS_W-1:0] + hash_second[bbf_pkg::POS_W-1:0];
			mask_q   <= '0;
		end else if (hleft_q != '0) begin
			mask_q <= mask_q | (bbf_pkg::BLOCK_BITS'(1) << pos_q);
			pos_q  <= pos_q + stride_q;
		end
		if (load_out) present_q <= ((rdata_q & mask_q) == mask_q);
	end

	// filter row RAM
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (mem_re) rdata_q <= mem[div_stat.rem];
	end

	assign out_valid = out_valid_q;
	assign present   = present_q;

endmodule

`default_nettype wire

>>> tb/sv/tb_blocked_bloom_filter_unit.sv
// ---------------------------------------------------------------------------
// tb_blocked_bloom_filter_unit
// Self-checking bench for the blocked Bloom filter unit. Sends insert and
// query transactions with random idle gaps on both channels, holds a bit-level
// copy of the filter store to predict every query answer, and steps through
// several block/hash count settings, including zero and saturating values.
// ---------------------------------------------------------------------------
module tb_blocked_bloom_filter_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1200000;
	localparam int TAIL_CYCLES = 100;
	localparam int HOLD_CYCLES = 1000;
	localparam int KEY_POOL_MAX = 256;
	localparam logic [bbf_pkg::CFG_IDX_W-1:0] REG_SPARE_0 = 2'd2;
	localparam logic [bbf_pkg::CFG_IDX_W-1:0] REG_SPARE_1 = 2'd3;

	typedef struct packed {
		logic                       op;
		logic [bbf_pkg::HASH_W-1:0] first;
		logic [bbf_pkg::HASH_W-1:0] second;
	} key_txn_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [bbf_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [bbf_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                           in_valid = 1'b0;
	logic                           in_ready;
	logic                           opcode = bbf_pkg::OP_INSERT;
	logic [bbf_pkg::HASH_W-1:0]     hash_first = '0;
	logic [bbf_pkg::HASH_W-1:0]     hash_second = '0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic                           present;

	// predictor state
	bit [bbf_pkg::BLOCK_BITS-1:0] filter_rows [bbf_pkg::MAX_BLOCKS];
	logic [bbf_pkg::NB_W-1:0]     cfg_blocks = 11'd1;
	logic [bbf_pkg::NH_W-1:0]     cfg_hashes = 5'd7;
	logic                         pending_answers [$];

	key_txn_t    key_queue [$];
	key_txn_t    known_keys [$];
	key_txn_t    drive_item;
	logic        item_taken = 1'b0;
	logic        send_next;
	int unsigned send_gap = 0;
	logic        take_next;
	int unsigned stall_left = 0;
	int unsigned hold_left = 0;
	logic        hold_request = 1'b0;
	logic        no_idle = 1'b0;

	int unsigned cycle_count = 0;
	int unsigned fail_count = 0;
	int unsigned inserts_in = 0;
	int unsigned queries_in = 0;
	int unsigned answers_checked = 0;
	int unsigned answers_present = 0;
	int unsigned settings_run = 0;

	blocked_bloom_filter_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.hash_first (hash_first),
		.hash_second(hash_second),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.present    (present)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) cycle_count++;

	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(1, 3);
		if (r < 95) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [bbf_pkg::HASH_W-1:0] rand_hash();
		case ($urandom_range(0, 15))
			0: return '0;
			1: return '1;
			2: return 64'd1 << $urandom_range(0, bbf_pkg::HASH_W - 1);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Updates the filter copy; a query leaves its answer behind.
	task automatic apply_key(input key_txn_t t);
		logic [bbf_pkg::HASH_W-1:0] rows_used;
		logic [bbf_pkg::HASH_W-1:0] row;
		logic [bbf_pkg::HASH_W-1:0] step;
		logic [bbf_pkg::HASH_W-1:0] sum;
		logic [bbf_pkg::POS_W-1:0]  pos;
		int unsigned                hashes_used;
		logic                       hit;
		if (cfg_blocks == '0)
			rows_used = bbf_pkg::HASH_W'(1);
		else if (cfg_blocks > bbf_pkg::NB_W'(bbf_pkg::MAX_BLOCKS))
			rows_used = bbf_pkg::HASH_W'(bbf_pkg::MAX_BLOCKS);
		else
			rows_used = bbf_pkg::HASH_W'(cfg_blocks);
		if (cfg_hashes > bbf_pkg::NH_W'(bbf_pkg::MAX_HASHES))
			hashes_used = bbf_pkg::MAX_HASHES;
		else
			hashes_used = 32'(cfg_hashes);
		row = t.first % rows_used;
		hit = 1'b1;
		for (int i = 1; i <= hashes_used; i++) begin
			step = bbf_pkg::HASH_W'(i);
			sum = t.first + step * t.second;
			pos = sum[bbf_pkg::POS_W-1:0];
			if (t.op == bbf_pkg::OP_INSERT)
				filter_rows[row[bbf_pkg::ROW_AW-1:0]][pos] = 1'b1;
			else if (!filter_rows[row[bbf_pkg::ROW_AW-1:0]][pos])
				hit = 1'b0;
		end
		if (t.op == bbf_pkg::OP_QUERY) pending_answers = {pending_answers, hit};
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			apply_key(drive_item);
			if (drive_item.op == bbf_pkg::OP_INSERT) inserts_in++;
			else queries_in++;
			item_taken = 1'b1;
		end
	end

	always @(negedge clk) begin
		send_next = in_valid;
		if (item_taken) begin
			item_taken = 1'b0;
			send_next = 1'b0;
			send_gap = (no_idle || $urandom_range(0, 99) < 55) ? 0 : idle_len();
		end
		if (!send_next && arst_n) begin
			if (send_gap > 0) begin
				send_gap--;
			end else if (key_queue.size() > 0) begin
				drive_item = key_queue.pop_front();
				opcode <= drive_item.op;
				hash_first <= drive_item.first;
				hash_second <= drive_item.second;
				send_next = 1'b1;
			end
		end
		in_valid <= send_next;
	end

	// receiver
	always @(negedge clk) begin
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			take_next = 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			take_next = 1'b0;
		end else if (!no_idle && $urandom_range(0, 99) < 25) begin
			stall_left = idle_len() - 1;
			take_next = 1'b0;
		end else begin
			take_next = 1'b1;
		end
		out_ready <= take_next;
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_answers.size() == 0) begin
				$error("present: unexpected transaction, expected none, actual %0b", present);
				fail_count++;
			end else begin
				logic want;
				want = pending_answers.pop_front();
				if (present !== want) begin
					$error("present: expected %0b, actual %0b", want, present);
					fail_count++;
				end
				answers_checked++;
				if (want) answers_present++;
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("CHECK FAILED");
		$finish;
	end

	task automatic write_reg(input logic [bbf_pkg::CFG_IDX_W-1:0] idx, input int unsigned val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= bbf_pkg::CFG_DATA_W'(val);
		case (idx)
			bbf_pkg::REG_NUM_BLOCKS: cfg_blocks = bbf_pkg::NB_W'(val);
			bbf_pkg::REG_NUM_HASHES: cfg_hashes = bbf_pkg::NH_W'(val);
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic push_key(input logic op, input logic [bbf_pkg::HASH_W-1:0] first,
			input logic [bbf_pkg::HASH_W-1:0] second);
		key_txn_t t;
		t.op = op;
		t.first = first;
		t.second = second;
		key_queue = {key_queue, t};
	endtask

	// Waits until the block has gone quiet.
	task automatic drain();
		while (key_queue.size() != 0 || in_valid || pending_answers.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// Mostly inserts and queries of earlier keys; some near misses and noise.
	task automatic make_random_item();
		key_txn_t    t;
		int unsigned pick;
		int unsigned k;
		pick = $urandom_range(0, 99);
		t.op = bbf_pkg::OP_QUERY;
		t.first = rand_hash();
		t.second = rand_hash();
		if (pick < 45) begin
			t.op = bbf_pkg::OP_INSERT;
			known_keys = {known_keys, t};
			if (known_keys.size() > KEY_POOL_MAX) void'(known_keys.pop_front());
		end else if (pick < 90 && known_keys.size() > 0) begin
			t = known_keys[$urandom_range(0, known_keys.size() - 1)];
			t.op = bbf_pkg::OP_QUERY;
			if (pick >= 80) begin
				k = $urandom_range(0, bbf_pkg::HASH_W - 1);
				if ($urandom_range(0, 1)) t.first[k] = ~t.first[k];
				else t.second[k] = ~t.second[k];
			end
		end
		key_queue = {key_queue, t};
	endtask

	task automatic run_random_phase(input int unsigned nb, input int unsigned nh,
			input int unsigned items, input logic burst, input logic squeeze);
		write_reg(bbf_pkg::REG_NUM_BLOCKS, nb);
		write_reg(bbf_pkg::REG_NUM_HASHES, nh);
		settings_run++;
		no_idle = burst;
		hold_request = squeeze;
		repeat (items) make_random_item();
		drain();
		no_idle = 1'b0;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (!in_ready) @(posedge clk);

		// reset setting: one block, seven hashes
		settings_run++;
		push_key(bbf_pkg::OP_QUERY, '0, '0);
		push_key(bbf_pkg::OP_INSERT, '0, '0);
		push_key(bbf_pkg::OP_QUERY, '0, '0);
		push_key(bbf_pkg::OP_QUERY, '0, 64'd1);
		push_key(bbf_pkg::OP_INSERT, '1, '1);
		push_key(bbf_pkg::OP_QUERY, '1, '1);
		push_key(bbf_pkg::OP_QUERY, '1, '0);
		push_key(bbf_pkg::OP_INSERT, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0200);
		push_key(bbf_pkg::OP_QUERY, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0200);
		drain();

		// zero counts: block 0 only, nothing touched, queries always hit
		write_reg(bbf_pkg::REG_NUM_BLOCKS, 0);
		write_reg(bbf_pkg::REG_NUM_HASHES, 0);
		settings_run++;
		push_key(bbf_pkg::OP_QUERY, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
		push_key(bbf_pkg::OP_INSERT, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
		push_key(bbf_pkg::OP_QUERY, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
		drain();

		// both counts saturate
		write_reg(bbf_pkg::REG_NUM_BLOCKS, 2047);
		write_reg(bbf_pkg::REG_NUM_HASHES, 31);
		settings_run++;
		push_key(bbf_pkg::OP_INSERT, '1, 64'd1);
		push_key(bbf_pkg::OP_QUERY, '1, 64'd1);
		push_key(bbf_pkg::OP_QUERY, 64'h0000_0000_0000_03FF, 64'd1);
		push_key(bbf_pkg::OP_QUERY, '1, '1);
		drain();

		// spare indexes are ignored; store survives reconfiguration
		write_reg(REG_SPARE_0, '1);
		write_reg(REG_SPARE_1, '1);
		write_reg(bbf_pkg::REG_NUM_BLOCKS, bbf_pkg::MAX_BLOCKS);
		write_reg(bbf_pkg::REG_NUM_HASHES, bbf_pkg::MAX_HASHES);
		settings_run++;
		push_key(bbf_pkg::OP_QUERY, '1, 64'd1);
		push_key(bbf_pkg::OP_INSERT, 64'd1024, '1);
		push_key(bbf_pkg::OP_QUERY, 64'd0, '1);
		push_key(bbf_pkg::OP_QUERY, 64'd1024, '1);
		drain();

		run_random_phase(1, 16, 190, 1'b0, 1'b0);
		run_random_phase(1024, 16, 190, 1'b0, 1'b0);
		run_random_phase(3, 1, 190, 1'b1, 1'b0);
		run_random_phase(2047, 31, 190, 1'b0, 1'b1);
		run_random_phase(0, 0, 190, 1'b0, 1'b0);
		run_random_phase(517, 4, 190, 1'b0, 1'b0);
		write_reg(REG_SPARE_0, $urandom_range(0, 2047));
		write_reg(REG_SPARE_1, $urandom_range(0, 2047));
		run_random_phase($urandom_range(0, 2047), $urandom_range(0, 31), 190, 1'b0, 1'b0);
		run_random_phase($urandom_range(1, 16), $urandom_range(0, 31), 190, 1'b0, 1'b0);
		run_random_phase($urandom_range(0, 2047), $urandom_range(1, 16), 190, 1'b1, 1'b0);
		run_random_phase(1000, 7, 190, 1'b0, 1'b0);

		$display("Run: %0d inserts and %0d queries over %0d count settings",
			inserts_in, queries_in, settings_run);
		$display("Run: %0d answers checked, %0d present, %0d absent",
			answers_checked, answers_present, answers_checked - answers_present);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
